@@ sv/pip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int COORD_BITS  = 16;
  // edge deltas carry one extra bit, products twice that
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DELTA_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    logic   kind;
    coord_t coord_x;
    coord_t coord_y;
    logic   last;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } out_item_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } edge_t;

  // one vertex request as handed from the front to the back
  typedef struct packed {
    logic   start;    // first vertex of a polygon: no leading edge, clear totals
    logic   last;     // closing edge is valid, emit a result
    coord_t qx;
    coord_t qy;
    edge_t  lead;     // previous vertex to this one
    edge_t  close;    // this vertex back to the first
  } job_t;

  // registered partial result of one edge
  typedef struct packed {
    prod_t prod_l;
    prod_t prod_r;
    logic  box_ok;
    logic  straddle;
    logic  ey_pos;
  } edge_prod_t;

endpackage

`default_nettype wire

@@ sv/pip_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_front import pip_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  coord_t qx_r, qy_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic   have_first_r;
  logic   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_data.kind == KIND_VERTEX);

  always_comb begin
    q_job.start    = !have_first_r;
    q_job.last     = in_data.last;
    q_job.qx       = qx_r;
    q_job.qy       = qy_r;
    q_job.lead.ax  = prev_x_r;
    q_job.lead.ay  = prev_y_r;
    q_job.lead.bx  = in_data.coord_x;
    q_job.lead.by  = in_data.coord_y;
    q_job.close.ax = in_data.coord_x;
    q_job.close.ay = in_data.coord_y;
    // a lone vertex closes onto itself
    q_job.close.bx = have_first_r ? first_x_r : in_data.coord_x;
    q_job.close.by = have_first_r ? first_y_r : in_data.coord_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r         <= '0;
      qy_r         <= '0;
      have_first_r <= 1'b0;
    end else if (accept) begin
      if (in_data.kind == KIND_QUERY) begin
        qx_r         <= in_data.coord_x;
        qy_r         <= in_data.coord_y;
        have_first_r <= 1'b0;
      end else begin
        have_first_r <= !in_data.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      prev_x_r <= in_data.coord_x;
      prev_y_r <= in_data.coord_y;
      if (!have_first_r) begin
        first_x_r <= in_data.coord_x;
        first_y_r <= in_data.coord_y;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pip_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_queue import pip_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      empty,
  output logic      full
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t                slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PTR_BITS:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ sv/pip_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_back import pip_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_t      head_job,
  input  wire logic      q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  function automatic edge_prod_t eval_edge(edge_t e, coord_t qx, coord_t qy);
    edge_prod_t res;
    delta_t     ex, ey, wx, wy;
    coord_t     lox, hix, loy, hiy;
    ex  = DELTA_BITS'(e.bx) - DELTA_BITS'(e.ax);
    ey  = DELTA_BITS'(e.by) - DELTA_BITS'(e.ay);
    wx  = DELTA_BITS'(qx) - DELTA_BITS'(e.ax);
    wy  = DELTA_BITS'(qy) - DELTA_BITS'(e.ay);
    lox = (e.ax < e.bx) ? e.ax : e.bx;
    hix = (e.ax < e.bx) ? e.bx : e.ax;
    loy = (e.ay < e.by) ? e.ay : e.by;
    hiy = (e.ay < e.by) ? e.by : e.ay;
    res.prod_l   = PROD_BITS'(ex) * PROD_BITS'(wy);
    res.prod_r   = PROD_BITS'(ey) * PROD_BITS'(wx);
    res.box_ok   = (qx >= lox) && (qx <= hix) && (qy >= loy) && (qy <= hiy);
    res.straddle = (e.ay > qy) != (e.by > qy);
    res.ey_pos   = (ey > 0);
    return res;
  endfunction

  // products registered here, compares and totals after
  logic       a_v_r;
  logic       a_start_r, a_last_r;
  edge_prod_t a_lead_r, a_close_r;
  logic       a_fire, a_load;

  logic       par_r, bnd_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic       b_ok;
  logic       lead_hit, lead_flip, close_hit, close_flip;
  logic       par_nxt, bnd_nxt;

  function automatic logic hit_of(edge_prod_t p);
    return (p.prod_l == p.prod_r) && p.box_ok;
  endfunction

  function automatic logic flip_of(edge_prod_t p);
    logic right;
    right = p.ey_pos ? (p.prod_l >= p.prod_r) : (p.prod_l <= p.prod_r);
    return p.straddle && right;
  endfunction

  assign b_ok   = !out_valid_r || out_ready;
  assign a_fire = a_v_r && (!a_last_r || b_ok);
  assign a_load = !a_v_r || a_fire;
  assign q_pop  = a_load && !q_empty;

  always_comb begin
    lead_hit   = !a_start_r && hit_of(a_lead_r);
    lead_flip  = !a_start_r && flip_of(a_lead_r);
    close_hit  = a_last_r && hit_of(a_close_r);
    close_flip = a_last_r && flip_of(a_close_r);
    par_nxt    = (a_start_r ? 1'b0 : par_r) ^ lead_flip ^ close_flip;
    bnd_nxt    = (a_start_r ? 1'b0 : bnd_r) | lead_hit | close_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      par_r       <= 1'b0;
      bnd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_v_r <= !q_empty;
      end
      if (a_fire) begin
        par_r <= par_nxt;
        bnd_r <= bnd_nxt;
      end
      if (a_fire && a_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_start_r <= head_job.start;
      a_last_r  <= head_job.last;
      a_lead_r  <= eval_edge(head_job.lead, head_job.qx, head_job.qy);
      a_close_r <= eval_edge(head_job.close, head_job.qx, head_job.qy);
    end
    if (a_fire && a_last_r) begin
      out_data_r.inside_res  <= bnd_nxt || par_nxt;
      out_data_r.on_boundary <= bnd_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/point_in_polygon_test.sv @@
// channel | handshake            | payload                              | moves
// in      | in_valid / in_ready  | in_data: kind, coord_x, coord_y, last | query or vertex
// out     | out_valid/ out_ready | out_data: inside_res, on_boundary     | one per polygon
//
// One request per cycle sustained while the queue is not full. A vertex request
// is written into the queue when accepted, its edge products are registered in
// the product stage, and a closing vertex's verdict then goes to the result register.
// A query updates the point in the front, restarts the polygon and uses no queue slot.
// Synchronous active-low reset clears the point to (0, 0) and all control.
// A stalled result holds only the back; the front keeps accepting until the
// two-entry queue fills, then drops in_ready.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test import pip_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic q_push, q_pop, q_empty, q_full;
  job_t push_job, head_job;

  // front: hold query point, first and previous vertex, build edge requests
  pip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // decouple: let the front advance while the back waits on out_ready
  pip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: cross products, boundary and parity totals, result register
  pip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ dv/tb_point_in_polygon_test.sv @@
`timescale 1ns / 1ps

module tb_point_in_polygon_test;
  import pip_pkg::*;

  // stimulus shaping
  localparam int RUN_REQUESTS = 1420;  // directed rows plus about 1400 random requests
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off that fills the block
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES  = 8;     // settle time after the last verdict
  localparam int MAX_VERTS    = 12;

  // how the coordinates of one random case are spread
  localparam int SPREAD_NEAR = 0;      // within a few units of a center
  localparam int SPREAD_WIDE = 1;      // within a couple of thousand units
  localparam int SPREAD_FULL = 2;      // anywhere in the signed range
  localparam int SPREAD_RAIL = 3;      // only values at or next to the extremes or zero

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  point_in_polygon_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Verdicts owed by the block, oldest first
  out_item_t verdicts_due[$];
  int        faults        = 0;
  int        requests_sent = 0;

  // Idling knobs, moved by the main sequence from phase to phase
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  bit rx_hold_req  = 1'b0;
  int rx_wait      = 0;

  // Predictor state: query point, first and previous vertex, running totals
  coord_t pt_x = '0, pt_y = '0;
  coord_t anchor_x = '0, anchor_y = '0;
  coord_t tail_x = '0, tail_y = '0;
  bit     open_poly = 1'b0;
  bit     crossing_odd = 1'b0;
  bit     touched = 1'b0;

  // Directed script: a request and, where obvious, the verdict it must bring
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script[$];

  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Score one edge a->b against the query point: boundary touch and ray crossing.
  // Products are formed wide so no comparison can wrap.
  function automatic void score_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint ex, ey, wx, wy, lhs, rhs;
    coord_t lo_x, hi_x, lo_y, hi_y;
    bit     right_of;
    ex   = longint'(bx) - longint'(ax);
    ey   = longint'(by) - longint'(ay);
    wx   = longint'(pt_x) - longint'(ax);
    wy   = longint'(pt_y) - longint'(ay);
    lhs  = ex * wy;
    rhs  = ey * wx;
    lo_x = (ax < bx) ? ax : bx;
    hi_x = (ax < bx) ? bx : ax;
    lo_y = (ay < by) ? ay : by;
    hi_y = (ay < by) ? by : ay;
    if (lhs == rhs && pt_x >= lo_x && pt_x <= hi_x && pt_y >= lo_y && pt_y <= hi_y)
      touched = 1'b1;
    // exactly one end strictly above the point's y
    if ((ay > pt_y) != (by > pt_y)) begin
      right_of = (ey > 0) ? (lhs >= rhs) : (lhs <= rhs);
      if (right_of) crossing_odd = ~crossing_odd;
    end
  endfunction

  // Fold one accepted request into the predictor; return 1 when it closes a polygon
  function automatic bit fold_request(in_item_t r, output out_item_t verdict);
    verdict = '0;
    if (r.kind == KIND_QUERY) begin
      pt_x         = r.coord_x;
      pt_y         = r.coord_y;
      open_poly    = 1'b0;
      crossing_odd = 1'b0;
      touched      = 1'b0;
      return 1'b0;
    end
    if (!open_poly) begin
      anchor_x  = r.coord_x;
      anchor_y  = r.coord_y;
      open_poly = 1'b1;
    end else begin
      score_edge(tail_x, tail_y, r.coord_x, r.coord_y);
    end
    tail_x = r.coord_x;
    tail_y = r.coord_y;
    if (!r.last) return 1'b0;
    // closing edge back to the first vertex
    score_edge(r.coord_x, r.coord_y, anchor_x, anchor_y);
    verdict.inside_res  = touched | crossing_odd;
    verdict.on_boundary = touched;
    open_poly    = 1'b0;
    crossing_odd = 1'b0;
    touched      = 1'b0;
    return 1'b1;
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  // Called at a rising edge; valid is only lowered when a gap follows.
  task automatic offer(in_item_t r, bit typed = 1'b0, out_item_t want = '0);
    int        gap;
    out_item_t verdict;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (fold_request(r, verdict))
      verdicts_due.push_back(typed ? want : verdict);
  endtask

  // Stop offering and wait until every owed verdict has come back
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic add_row(logic kind, int x, int y, logic last,
                         bit typed = 1'b0, logic ins = 1'b0, logic onb = 1'b0);
    script_row_t row;
    row.req.kind          = kind;
    row.req.coord_x       = coord_t'(x);
    row.req.coord_y       = coord_t'(y);
    row.req.last          = last;
    row.typed             = typed;
    row.want.inside_res   = ins;
    row.want.on_boundary  = onb;
    script.push_back(row);
  endtask

  function automatic coord_t pick_coord(int spread, longint center);
    int off;
    case (spread)
      SPREAD_NEAR: begin
        off = int'($urandom_range(0, 16)) - 8;
        return coord_t'(center + off);
      end
      SPREAD_WIDE: begin
        off = int'($urandom_range(0, 4000)) - 2000;
        return coord_t'(center + off);
      end
      SPREAD_RAIL: begin
        case ($urandom_range(0, 6))
          0: return coord_t'(-32768);
          1: return coord_t'(-32767);
          2: return coord_t'(-1);
          3: return coord_t'(0);
          4: return coord_t'(1);
          5: return coord_t'(32766);
          default: return coord_t'(32767);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // One random case: a query point, then a polygon, last vertex flagged.
  // A share of cases skip the query, flag last on the query, or break the polygon
  // with a stray query part way through.
  task automatic send_polygon_case();
    coord_t   vx[MAX_VERTS];
    coord_t   vy[MAX_VERTS];
    int       n, spread, sel, i, j, k, break_at;
    longint   cx, cy;
    coord_t   qx, qy;
    in_item_t r;
    sel = $urandom_range(0, 99);
    if (sel < 10)      n = 1;
    else if (sel < 20) n = 2;
    else if (sel < 85) n = $urandom_range(3, 6);
    else               n = $urandom_range(7, MAX_VERTS);
    sel = $urandom_range(0, 9);
    if (sel < 5)      spread = SPREAD_NEAR;
    else if (sel < 7) spread = SPREAD_WIDE;
    else if (sel < 8) spread = SPREAD_FULL;
    else              spread = SPREAD_RAIL;
    cx = ($urandom_range(0, 3) == 0) ? 0 : longint'(int'($urandom_range(0, 65535)) - 32768);
    cy = ($urandom_range(0, 3) == 0) ? 0 : longint'(int'($urandom_range(0, 65535)) - 32768);
    for (i = 0; i < n; i++) begin
      vx[i] = pick_coord(spread, cx);
      vy[i] = pick_coord(spread, cy);
    end
    // place the point: near the polygon, on a vertex, at an edge midpoint, or anywhere
    j = $urandom_range(0, n - 1);
    k = (j + 1) % n;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      qx = pick_coord(spread, cx);
      qy = pick_coord(spread, cy);
    end else if (sel < 6) begin
      qx = vx[j];
      qy = vy[j];
    end else if (sel < 8) begin
      qx = coord_t'((longint'(vx[j]) + longint'(vx[k])) >>> 1);
      qy = coord_t'((longint'(vy[j]) + longint'(vy[k])) >>> 1);
    end else begin
      qx = coord_t'($urandom);
      qy = coord_t'($urandom);
    end
    if ($urandom_range(0, 9) != 0) begin
      r.kind    = KIND_QUERY;
      r.coord_x = qx;
      r.coord_y = qy;
      r.last    = ($urandom_range(0, 9) == 0);
      offer(r);
    end
    break_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1;
    for (i = 0; i < n; i++) begin
      if (i == break_at) begin
        r.kind    = KIND_QUERY;
        r.coord_x = coord_t'($urandom);
        r.coord_y = coord_t'($urandom);
        r.last    = 1'($urandom_range(0, 1));
        offer(r);
      end
      r.kind    = KIND_VERTEX;
      r.coord_x = vx[i];
      r.coord_y = vy[i];
      r.last    = (i == n - 1);
      offer(r);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked, counted here
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_wait     = HOLD_CYCLES;
    end
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_ready <= 1'b0;
      rx_wait = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker: compare every accepted verdict with the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict: inside_res=%0b on_boundary=%0b",
               out_data.inside_res, out_data.on_boundary);
        faults++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.inside_res !== want.inside_res) begin
          $error("inside_res: expected %0b, got %0b", want.inside_res, out_data.inside_res);
          faults++;
        end
        if (out_data.on_boundary !== want.on_boundary) begin
          $error("on_boundary: expected %0b, got %0b", want.on_boundary,
                 out_data.on_boundary);
          faults++;
        end
      end
    end
  end

  // Watchdog: give up after too many cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end while (idle < STALL_LIMIT);
    $display("point_in_polygon_test: mismatch");
    $finish;
  end

  initial begin
    int phase, next_shift;

    // Directed rows. Typed verdicts are the ones that follow at a glance:
    // a lone vertex is a degenerate edge, so it touches only its own point.
    add_row(KIND_VERTEX, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1);       // vertex before any query
    add_row(KIND_QUERY, 5, 5, 1'b1);                          // query with last: ignore last
    add_row(KIND_VERTEX, 5, 5, 1'b1, 1'b1, 1'b1, 1'b1);       // lone vertex on the point
    add_row(KIND_VERTEX, 6, 5, 1'b1, 1'b1, 1'b0, 1'b0);       // lone vertex off the point
    // full-range square around the origin
    add_row(KIND_QUERY, 0, 0, 1'b0);
    add_row(KIND_VERTEX, -32768, -32768, 1'b0);
    add_row(KIND_VERTEX, 32767, -32768, 1'b0);
    add_row(KIND_VERTEX, 32767, 32767, 1'b0);
    add_row(KIND_VERTEX, -32768, 32767, 1'b1);
    // point at the negative corner, lone vertex at the positive corner
    add_row(KIND_QUERY, -32768, -32768, 1'b0);
    add_row(KIND_VERTEX, 32767, 32767, 1'b1, 1'b1, 1'b0, 1'b0);
    // triangle around the point, then a new polygon far away for the same point
    add_row(KIND_QUERY, 15, 12, 1'b0);
    add_row(KIND_VERTEX, 10, 10, 1'b0);
    add_row(KIND_VERTEX, 20, 10, 1'b0);
    add_row(KIND_VERTEX, 15, 20, 1'b1);
    add_row(KIND_VERTEX, 100, 100, 1'b0);
    add_row(KIND_VERTEX, 200, 100, 1'b0);
    add_row(KIND_VERTEX, 150, 200, 1'b1, 1'b1, 1'b0, 1'b0);
    // diamond whose side vertices sit on the point's horizontal ray
    add_row(KIND_QUERY, 0, 0, 1'b0);
    add_row(KIND_VERTEX, -5, 0, 1'b0);
    add_row(KIND_VERTEX, 0, -5, 1'b0);
    add_row(KIND_VERTEX, 5, 0, 1'b0);
    add_row(KIND_VERTEX, 0, 5, 1'b1);

    // hold reset, then release it at an edge
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (script[i]) offer(script[i].req, script[i].typed, script[i].want);

    // Random part opens with a long receiver hold-off while requests keep
    // coming back to back, so the queue fills and in_ready drops.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b1;
    phase        = 0;
    next_shift   = requests_sent + 200;
    while (requests_sent < RUN_REQUESTS) begin
      if (requests_sent >= next_shift) begin
        phase++;
        next_shift += 200;
        case (phase % 4)
          0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_gap_pct = 30; rx_stall_pct = 30; end
          2: begin tx_gap_pct = 10; rx_stall_pct = 60; end
          default: begin tx_gap_pct = 60; rx_stall_pct = 10; end
        endcase
        // pause the sender once until the block has handed back everything
        if (phase == 3) wait_for_verdicts();
        if (phase == 5) rx_hold_req = 1'b1;
      end
      send_polygon_case();
    end

    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && verdicts_due.size() == 0) begin
      $display("point_in_polygon_test: match");
    end else begin
      $display("point_in_polygon_test: mismatch");
    end
    $finish;
  end

endmodule
